>>> sv/asymmetric_soft_knee_shaper_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the asymmetric soft-knee shaper.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef ASYMMETRIC_SOFT_KNEE_SHAPER_TOP_MACROS_SVH
`define ASYMMETRIC_SOFT_KNEE_SHAPER_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define ASK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, also during reset.
`define ASK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ask_pkg.sv
// ----------------------------------------------------------------------------
// ask_pkg
// Shared types, constants and arithmetic helpers of the soft-knee shaper.
// ----------------------------------------------------------------------------
package ask_pkg;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned XW     = 38;
  localparam int unsigned EW     = 37;
  localparam int unsigned KW     = 25;
  localparam int unsigned QW     = 25;
  localparam int unsigned LimW   = 25;
  localparam int unsigned NumW   = 62;
  localparam int unsigned KneeLat = QW + 2;

  localparam int unsigned FifoDepth = 4;

  localparam logic [23:0] DriveLo  = 24'd1028;
  localparam logic [23:0] DriveHi  = 24'd16306176;
  localparam logic [23:0] DriveRst = 24'd4096;
  localparam logic signed [15:0] BiasLo = -16'sd16384;
  localparam logic signed [15:0] BiasHi = 16'sd16384;
  localparam logic [16:0] AsymHi   = 17'd65536;
  localparam logic [15:0] KneeLo   = 16'd2;
  localparam logic [15:0] KneeHi   = 16'd32768;
  localparam logic [15:0] KneeRst  = 16'd16384;
  localparam logic [23:0] MakeupLo  = 24'd4135;
  localparam logic [23:0] MakeupHi  = 24'd16461860;
  localparam logic [23:0] MakeupRst = 24'd65536;
  localparam logic [19:0] TrimLo  = 20'd261;
  localparam logic [19:0] TrimHi  = 20'd1038673;
  localparam logic [19:0] TrimRst = 20'd65536;

  localparam logic [23:0] UpperBase = 24'd7549747;
  localparam logic [22:0] UpperSpan = 23'd4613734;
  localparam logic [23:0] LowerBase = 24'd7549747;
  localparam logic [22:0] LowerSpan = 23'd4865393;

  typedef enum logic [1:0] {
    CLS_INSIDE,
    CLS_ABOVE,
    CLS_BELOW
  } cls_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DRIVE,
    REG_BIAS,
    REG_ASYM,
    REG_KNEE,
    REG_MAKEUP,
    REG_TRIM
  } reg_e;

  typedef struct packed {
    logic [23:0]            drive;
    logic signed [LimW-1:0] bias23;
    logic signed [LimW-1:0] up;
    logic signed [LimW-1:0] lo;
    logic [KW-1:0]          knee;
    logic [23:0]            makeup;
    logic [19:0]            trim;
  } cfg_t;

  typedef struct packed {
    cls_e                 cls;
    logic signed [XW-1:0] x;
    logic [EW-1:0]        e;
  } front_t;

  // Right shift that rounds to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // Places a value against the limits and gives the excess past the limit.
  function automatic front_t classify(input logic signed [XW-1:0] x,
                                      input logic signed [LimW-1:0] up,
                                      input logic signed [LimW-1:0] lo);
    front_t r;
    logic signed [XW-1:0] upx;
    logic signed [XW-1:0] lox;
    upx = XW'(up);
    lox = XW'(lo);
    r.x = x;
    if (x > upx) begin
      r.cls = CLS_ABOVE;
      r.e   = EW'(x - upx);
    end else if (x < lox) begin
      r.cls = CLS_BELOW;
      r.e   = EW'(lox - x);
    end else begin
      r.cls = CLS_INSIDE;
      r.e   = '0;
    end
    return r;
  endfunction

endpackage

>>> sv/ask_front.sv
// ----------------------------------------------------------------------------
// ask_front
// Applies drive and bias to each sample and classifies it against the limits.
// ----------------------------------------------------------------------------
module ask_front import ask_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  output logic                      push_o,
  output front_t                    push_data_o,
  input  logic                      full_i
);

  localparam int unsigned PW = SampleW + 25;

  logic                      v1_q, v2_q, v3_q;
  logic                      adv1, adv2, adv3;
  logic signed [SampleW-1:0] s_q;
  logic signed [PW-1:0]      p_q, p_d;
  front_t                    d3_q, d3_d;
  logic signed [XW-1:0]      x;

  assign adv3       = !v3_q || !full_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign push_o     = v3_q && !full_i;
  assign push_data_o = d3_q;

  always_comb begin
    p_d  = PW'(s_q) * $signed(PW'({1'b0, cfg_i.drive}));
    x    = XW'(rnd_shift(64'(p_q), 12)) + XW'(cfg_i.bias23);
    d3_d = classify(x, cfg_i.up, cfg_i.lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s_q  <= sample_in_i;
    if (adv2) p_q  <= p_d;
    if (adv3) d3_q <= d3_d;
  end

endmodule

>>> sv/ask_fifo.sv
// ----------------------------------------------------------------------------
// ask_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module ask_fifo import ask_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] dout_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

endmodule

>>> sv/ask_knee_div.sv
// ----------------------------------------------------------------------------
// ask_knee_div
// Pipelined knee term round(e*k/(e+k)), one quotient bit per stage.
// ----------------------------------------------------------------------------
module ask_knee_div import ask_pkg::*; #(
  parameter int unsigned TagW = 2
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [EW-1:0]   e_i,
  input  logic [KW-1:0]   k_i,
  input  logic [TagW-1:0] tag_i,
  output logic [QW-1:0]   q_o,
  output logic [TagW-1:0] tag_o
);

  localparam int unsigned ELoW = 19;
  localparam int unsigned EHiW = EW - ELoW;
  localparam int unsigned DW   = EW + 1;

  logic [ELoW+KW-1:0] pl_q;
  logic [EHiW+KW-1:0] ph_q;
  logic [DW-1:0]      den_q;
  logic [TagW-1:0]    mtag_q;

  logic [NumW-1:0] rem_q [QW];
  logic [DW-1:0]   d_q   [QW];
  logic [QW-1:0]   qt_q  [QW+1];
  logic [TagW-1:0] tag_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q     <= (ELoW+KW)'(e_i[ELoW-1:0]) * (ELoW+KW)'(k_i);
      ph_q     <= (EHiW+KW)'(e_i[EW-1:ELoW]) * (EHiW+KW)'(k_i);
      den_q    <= DW'(e_i) + DW'(k_i);
      mtag_q   <= tag_i;
      rem_q[0] <= (NumW'(ph_q) << ELoW) + NumW'(pl_q) + NumW'(den_q >> 1);
      d_q[0]   <= den_q;
      qt_q[0]  <= '0;
      tag_q[0] <= mtag_q;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned Bit = QW - 1 - j;
    logic [NumW-1:0] trial;
    logic            take;

    assign trial = NumW'(d_q[j]) << Bit;
    assign take  = rem_q[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qt_q[j+1]  <= qt_q[j] | (QW'(take) << Bit);
        tag_q[j+1] <= tag_q[j];
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= take ? rem_q[j] - trial : rem_q[j];
          d_q[j+1]   <= d_q[j];
        end
      end
    end
  end

  assign q_o   = qt_q[QW];
  assign tag_o = tag_q[QW];

endmodule

>>> sv/ask_back.sv
// ----------------------------------------------------------------------------
// ask_back
// Computes the knee terms, removes the bias response and applies the gains.
// ----------------------------------------------------------------------------
module ask_back import ask_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  input  front_t                 in_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] sample_out_o,
  output logic                   clipped_o
);

  localparam int unsigned YW   = 28;
  localparam int unsigned P1W  = YW + 25;
  localparam int unsigned Y2W  = 38;
  localparam int unsigned P2W  = Y2W + 21;
  localparam int unsigned XTW  = XW + 2;
  localparam logic signed [63:0] SatHi = 64'sd2147483647;
  localparam logic signed [63:0] SatLo = -64'sd2147483648;

  logic               adv;
  logic [KneeLat-1:0] kv_q;
  logic               c_vld_q, p1_vld_q, y2_vld_q, p2_vld_q, out_vld_q;

  front_t               b_cls;
  logic [XTW-1:0]       xtag;
  logic [1:0]           btag;
  logic [QW-1:0]        qx, qb;
  logic signed [XW-1:0] fx, fb;

  logic signed [YW-1:0]  y_q, y_d;
  logic signed [P1W-1:0] p1_q, p1_d;
  logic signed [Y2W-1:0] y2_q, y2_d;
  logic signed [P2W-1:0] p2_q, p2_d;
  logic signed [63:0]    y3;
  logic signed [OutW-1:0] out_q, out_d;
  logic                   clip_q, clip_d;

  function automatic logic signed [XW-1:0] lim_apply(input cls_e c,
                                                     input logic signed [XW-1:0] x,
                                                     input logic [QW-1:0] q,
                                                     input logic signed [LimW-1:0] up,
                                                     input logic signed [LimW-1:0] lo);
    logic signed [XW-1:0] r;
    case (c)
      CLS_ABOVE: r = XW'(up) + $signed(XW'(q));
      CLS_BELOW: r = XW'(lo) - $signed(XW'(q));
      default:   r = x;
    endcase
    return r;
  endfunction

  assign adv          = !out_vld_q || !out_stall_i;
  assign pop_o        = adv && in_valid_i;
  assign out_valid_o  = out_vld_q;
  assign sample_out_o = out_q;
  assign clipped_o    = clip_q;

  assign b_cls = classify(XW'(cfg_i.bias23), cfg_i.up, cfg_i.lo);

  ask_knee_div #(.TagW(XTW)) u_knee_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .e_i   (in_data_i.e),
    .k_i   (cfg_i.knee),
    .tag_i ({in_data_i.cls, in_data_i.x}),
    .q_o   (qx),
    .tag_o (xtag)
  );

  ask_knee_div #(.TagW(2)) u_knee_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .e_i   (b_cls.e),
    .k_i   (cfg_i.knee),
    .tag_i (b_cls.cls),
    .q_o   (qb),
    .tag_o (btag)
  );

  always_comb begin
    fx     = lim_apply(cls_e'(xtag[XTW-1:XW]), $signed(xtag[XW-1:0]), qx,
                       cfg_i.up, cfg_i.lo);
    fb     = lim_apply(cls_e'(btag), XW'(cfg_i.bias23), qb, cfg_i.up, cfg_i.lo);
    y_d    = YW'(fb - fx);
    p1_d   = P1W'(y_q) * $signed(P1W'({1'b0, cfg_i.makeup}));
    y2_d   = Y2W'(rnd_shift(64'(p1_q), 16));
    p2_d   = P2W'(y2_q) * $signed(P2W'({1'b0, cfg_i.trim}));
    y3     = rnd_shift(64'(p2_q), 24);
    clip_d = 1'b0;
    out_d  = OutW'(y3);
    if (y3 > SatHi) begin
      out_d  = OutW'(SatHi);
      clip_d = 1'b1;
    end else if (y3 < SatLo) begin
      out_d  = OutW'(SatLo);
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q      <= '0;
      c_vld_q   <= 1'b0;
      p1_vld_q  <= 1'b0;
      y2_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      kv_q      <= {kv_q[KneeLat-2:0], pop_o};
      c_vld_q   <= kv_q[KneeLat-1];
      p1_vld_q  <= c_vld_q;
      y2_vld_q  <= p1_vld_q;
      p2_vld_q  <= y2_vld_q;
      out_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q    <= y_d;
      p1_q   <= p1_d;
      y2_q   <= y2_d;
      p2_q   <= p2_d;
      out_q  <= out_d;
      clip_q <= clip_d;
    end
  end

endmodule

>>> sv/asymmetric_soft_knee_shaper_top.sv
// ----------------------------------------------------------------------------
// asymmetric_soft_knee_shaper_top
// Throughput is one sample per cycle while out_stall_i is low;
// the pipelined knee dividers set the depth.
// Reset loads the default settings and empties every stage; no clearing pass.
// ----------------------------------------------------------------------------
module asymmetric_soft_knee_shaper_top import ask_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OutW-1:0]     sample_out_o,
  output logic                       clipped_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned FW = $bits(front_t);

  logic [23:0]        drive_q, makeup_q;
  logic signed [15:0] bias_q;
  logic [16:0]        asym_q;
  logic [15:0]        knee_q;
  logic [19:0]        trim_q;
  cfg_t               cfg_q, cfg_d;

  logic [23:0]        drive_c, makeup_c;
  logic signed [15:0] bias_c;
  logic [16:0]        asym_c;
  logic [15:0]        knee_c;
  logic [19:0]        trim_c;
  logic [39:0]        up_prod, lo_prod;
  logic signed [LimW-1:0] lo_mag;

  logic   push, full, pop, q_valid;
  front_t push_data;
  logic [FW-1:0] q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q  <= DriveRst;
      bias_q   <= '0;
      asym_q   <= '0;
      knee_q   <= KneeRst;
      makeup_q <= MakeupRst;
      trim_q   <= TrimRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DRIVE:  drive_q  <= cfg_data_i[23:0];
        REG_BIAS:   bias_q   <= $signed(cfg_data_i[15:0]);
        REG_ASYM:   asym_q   <= cfg_data_i[16:0];
        REG_KNEE:   knee_q   <= cfg_data_i[15:0];
        REG_MAKEUP: makeup_q <= cfg_data_i[23:0];
        REG_TRIM:   trim_q   <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    drive_c  = (drive_q < DriveLo) ? DriveLo : ((drive_q > DriveHi) ? DriveHi : drive_q);
    bias_c   = (bias_q < BiasLo) ? BiasLo : ((bias_q > BiasHi) ? BiasHi : bias_q);
    asym_c   = (asym_q > AsymHi) ? AsymHi : asym_q;
    knee_c   = (knee_q < KneeLo) ? KneeLo : ((knee_q > KneeHi) ? KneeHi : knee_q);
    makeup_c = (makeup_q < MakeupLo) ? MakeupLo :
               ((makeup_q > MakeupHi) ? MakeupHi : makeup_q);
    trim_c   = (trim_q < TrimLo) ? TrimLo : ((trim_q > TrimHi) ? TrimHi : trim_q);
    up_prod  = 40'(asym_c) * 40'(UpperSpan);
    lo_prod  = 40'(asym_c) * 40'(LowerSpan);
    lo_mag   = $signed(LimW'(LowerBase) - LimW'((lo_prod + 40'd32768) >> 16));
    cfg_d.drive  = drive_c;
    cfg_d.bias23 = LimW'(bias_c) <<< 9;
    cfg_d.up     = $signed(LimW'(UpperBase) + LimW'((up_prod + 40'd32768) >> 16));
    cfg_d.lo     = -lo_mag;
    cfg_d.knee   = KW'(knee_c) << 9;
    cfg_d.makeup = makeup_c;
    cfg_d.trim   = trim_c;
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  ask_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ask_fifo #(.Width(FW), .Depth(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .dout_o  (q_data)
  );

  ask_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (q_valid),
    .in_data_i    (front_t'(q_data)),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

>>> sv/ask_checker.sv
// ----------------------------------------------------------------------------
// ask_checker
// Port-level checks of the shaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "asymmetric_soft_knee_shaper_top_macros.svh"

module ask_checker import ask_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [OutW-1:0]    sample_out_o,
  input logic                      clipped_o
);

  `ASK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `ASK_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(sample_out_o) && $stable(clipped_o), "stalled result changed")
  `ASK_ASSERT(a_clip_rail, clk_i, rst_ni, out_valid_o && clipped_o |-> (sample_out_o == 32'sh7FFFFFFF || sample_out_o == 32'sh80000000), "clipped result not at a rail")
  `ASK_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o, "pipeline not empty in reset")

endmodule

bind asymmetric_soft_knee_shaper_top ask_checker u_ask_checker (.*);
